[design/cscspmv_pkg.sv]
// ============================================================================
// cscspmv_pkg
// Shared types, widths and codes for the compressed-column sparse
// matrix-vector multiplier.
// ============================================================================
package cscspmv_pkg;

    localparam int MAX_ROWS_DEFAULT = 4096;

    localparam int CMD_W      = 2;
    localparam int ROW_W      = 12;
    localparam int VALUE_W    = 32;
    localparam int NUM_ROWS_W = 13;
    localparam int MODE_W     = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE = 1'b1;

    localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NONZERO = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_STORE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEGATE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SUBTRACT = 2'd3;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RESET    = 13'd4096;
    localparam logic [MODE_W-1:0]     OUTPUT_MODE_RESET = MODE_STORE;

    localparam logic STATUS_EMITTED = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [ROW_W-1:0]          row_index;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [ROW_W-1:0]          result_row;
        logic                      last_row;
        logic                      status;
    } result_t;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_MAC    = 2'd1,
        OP_EMIT   = 2'd2,
        OP_REJECT = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic                      last;
        logic [ROW_W-1:0]          raw_row;
        logic signed [VALUE_W-1:0] value;
    } op_t;

endpackage

[design/csc_sparse_matrix_vector_multiply.sv]
// ============================================================================
// csc_sparse_matrix_vector_multiply
// Sparse matrix times vector, matrix streamed in compressed-column order.
//
// Items arrive on item/item_valid/item_stall: begin column (latch x[j]),
// nonzero (acc[row] += a * x[j], Q16.16, saturating) and emit (next row out
// with the output mode applied, accumulator cleared). Results leave on
// result/result_valid/result_stall; a transfer takes place when valid is
// high and stall is low. cfg_write_enable writes num_rows or output_mode;
// the user must do so only while the block is idle; the block does not
// enforce it. After reset the accumulator memory is cleared, one row per
// cycle; item_stall stays high until the pass ends.
// A short queue separates the decoding front from the execution back.
// The back finishes each item before taking the next: a nonzero reads and
// multiplies, rounds, then writes on the single accumulator port pair; an
// emit reads, then loads the result and clears the row; begins and drops
// retire in idle. While result_stall is high the pending result holds; the
// queue keeps taking items until it fills, then item_stall rises.
// ============================================================================
module csc_sparse_matrix_vector_multiply #(
    parameter int MAX_ROWS = cscspmv_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  cscspmv_pkg::item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output cscspmv_pkg::result_t                result,
    input  logic                                cfg_write_enable,
    input  logic [cscspmv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cscspmv_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cscspmv_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW = $bits(op_t) + AW;

    logic [NUM_ROWS_W-1:0] num_rows_reg;
    logic [MODE_W-1:0]     output_mode_reg;

    logic                  clear_busy;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  push;
    logic                  pop;
    op_t                   front_op;
    logic [AW-1:0]         front_addr;
    op_t                   back_op;
    logic [AW-1:0]         back_addr;
    logic [QW-1:0]         q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= NUM_ROWS_RESET;
            output_mode_reg <= OUTPUT_MODE_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_NUM_ROWS:    num_rows_reg    <= cfg_data[NUM_ROWS_W-1:0];
                REG_OUTPUT_MODE: output_mode_reg <= cfg_data[MODE_W-1:0];
                default:         num_rows_reg    <= num_rows_reg;
            endcase
        end
    end

    cscspmv_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .num_rows   (num_rows_reg),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .push       (push),
        .op         (front_op),
        .op_addr    (front_addr)
    );

    cscspmv_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     ({front_op, front_addr}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    assign back_op   = q_rdata[QW-1:AW];
    assign back_addr = q_rdata[AW-1:0];

    cscspmv_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .op           (back_op),
        .op_addr      (back_addr),
        .q_pop        (pop),
        .output_mode  (output_mode_reg),
        .clear_busy   (clear_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[design/cscspmv_ram.sv]
// ============================================================================
// cscspmv_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cscspmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cscspmv_front.sv]
// ============================================================================
// cscspmv_front
// Accepts items, classifies them, range-checks nonzeros and sequences the
// emitted row numbers.
// ============================================================================
module cscspmv_front #(
    parameter int MAX_ROWS = cscspmv_pkg::MAX_ROWS_DEFAULT,
    localparam int AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  cscspmv_pkg::item_t                     item,
    input  logic [cscspmv_pkg::NUM_ROWS_W-1:0]     num_rows,
    input  logic                                   clear_busy,
    input  logic                                   q_full,
    output logic                                   push,
    output cscspmv_pkg::op_t                       op,
    output logic [AW-1:0]                          op_addr
);
    import cscspmv_pkg::*;

    localparam int NW = ($clog2(MAX_ROWS + 1) > NUM_ROWS_W) ? $clog2(MAX_ROWS + 1)
                                                             : NUM_ROWS_W;

    logic [AW-1:0] emit_counter_reg;
    logic [AW-1:0] emit_counter_next;
    logic [NW-1:0] num_rows_ext;
    logic [NW-1:0] rows_eff;
    logic [AW-1:0] emit_row;
    logic          emit_last;
    logic          xfer;

    assign item_stall   = q_full || clear_busy;
    assign xfer         = item_valid && !item_stall;
    assign num_rows_ext = NW'(num_rows);

    always_comb
    begin
        if (num_rows == '0)
        begin
            rows_eff = NW'(1);
        end
        else if (num_rows_ext > NW'(MAX_ROWS))
        begin
            rows_eff = NW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = num_rows_ext;
        end
    end

    // counter past the end (row count lowered) restarts at row 0
    assign emit_row  = (NW'(emit_counter_reg) >= rows_eff) ? '0 : emit_counter_reg;
    assign emit_last = (NW'(emit_row) == (rows_eff - NW'(1)));

    always_comb
    begin
        push              = 1'b0;
        emit_counter_next = emit_counter_reg;
        op.kind           = OP_BEGIN;
        op.last           = 1'b0;
        op.raw_row        = item.row_index;
        op.value          = item.value;
        op_addr           = AW'(item.row_index);
        case (item.command)
            CMD_BEGIN:
            begin
                push = xfer;
            end
            CMD_NONZERO:
            begin
                push = xfer;
                if (NW'(item.row_index) >= rows_eff)
                begin
                    op.kind = OP_REJECT;
                end
                else
                begin
                    op.kind = OP_MAC;
                end
            end
            CMD_EMIT:
            begin
                push       = xfer;
                op.kind    = OP_EMIT;
                op.last    = emit_last;
                op.raw_row = ROW_W'(emit_row);
                op_addr    = emit_row;
                if (xfer)
                begin
                    emit_counter_next = emit_last ? '0 : AW'(emit_row + 1'b1);
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_counter_reg <= '0;
        end
        else
        begin
            emit_counter_reg <= emit_counter_next;
        end
    end

endmodule

[design/cscspmv_queue.sv]
// ============================================================================
// cscspmv_queue
// Two-entry queue that decouples the front from the back.
// ============================================================================
module cscspmv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rdata     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[design/cscspmv_back.sv]
// ============================================================================
// cscspmv_back
// Executes queued operations against the row accumulator memory: latches
// the column value, multiply-accumulates, emits rows, runs the clearing pass.
// ============================================================================
module cscspmv_back #(
    parameter int MAX_ROWS = cscspmv_pkg::MAX_ROWS_DEFAULT,
    localparam int AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  cscspmv_pkg::op_t                   op,
    input  logic [AW-1:0]                      op_addr,
    output logic                               q_pop,
    input  logic [cscspmv_pkg::MODE_W-1:0]     output_mode,
    output logic                               clear_busy,
    output logic                               result_valid,
    input  logic                               result_stall,
    output cscspmv_pkg::result_t               result
);
    import cscspmv_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RND  = 4'b0010,
        ST_WB   = 4'b0100,
        ST_EMIT = 4'b1000
    } back_state_t;

    localparam logic signed [48:0] Q_MAX_W = 49'sd2147483647;
    localparam logic signed [48:0] Q_MIN_W = -49'sd2147483648;

    function automatic logic signed [VALUE_W-1:0] sat_q(input logic signed [48:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > Q_MAX_W)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < Q_MIN_W)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

    back_state_t               state_reg;
    back_state_t               state_next;
    logic                      clear_busy_reg;
    logic [AW-1:0]             clear_addr_reg;
    logic signed [VALUE_W-1:0] column_reg;
    logic signed [VALUE_W-1:0] column_next;
    op_t                       op_reg;
    logic [AW-1:0]             addr_reg;
    logic signed [63:0]        product_reg;
    logic signed [47:0]        qprod_reg;
    logic signed [63:0]        rounded;
    logic                      result_valid_reg;
    result_t                   result_reg;
    result_t                   result_next;
    logic                      result_load;
    logic                      can_load;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic                      ram_re;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] acc;
    logic signed [32:0]        emit_sum;

    cscspmv_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ROWS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (op_addr),
        .rdata (ram_rdata)
    );

    assign acc          = ram_rdata;
    assign clear_busy   = clear_busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign can_load     = !result_valid_reg || !result_stall;
    assign rounded      = product_reg + 64'sd32768;

    always_comb
    begin
        case (output_mode)
            MODE_STORE:    emit_sum = 33'(acc);
            MODE_NEGATE:   emit_sum = -33'(acc);
            MODE_ADD:      emit_sum = 33'(op_reg.value) + 33'(acc);
            MODE_SUBTRACT: emit_sum = 33'(op_reg.value) - 33'(acc);
            default:       emit_sum = 33'(acc);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        q_pop       = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = '0;
        column_next = column_reg;
        result_load = 1'b0;
        result_next = result_reg;
        if (clear_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (op.kind)
                            OP_BEGIN:
                            begin
                                q_pop       = 1'b1;
                                column_next = op.value;
                            end
                            OP_MAC:
                            begin
                                q_pop      = 1'b1;
                                ram_re     = 1'b1;
                                state_next = ST_RND;
                            end
                            OP_EMIT:
                            begin
                                q_pop      = 1'b1;
                                ram_re     = 1'b1;
                                state_next = ST_EMIT;
                            end
                            OP_REJECT:
                            begin
                                if (can_load)
                                begin
                                    q_pop                    = 1'b1;
                                    result_load              = 1'b1;
                                    result_next.result_value = '0;
                                    result_next.result_row   = op.raw_row;
                                    result_next.last_row     = 1'b0;
                                    result_next.status       = STATUS_DROPPED;
                                end
                            end
                            default:
                            begin
                                q_pop = 1'b1;
                            end
                        endcase
                    end
                end
                ST_RND:
                begin
                    state_next = ST_WB;
                end
                ST_WB:
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = sat_q(49'(acc) + 49'(qprod_reg));
                    state_next = ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        ram_we                   = 1'b1;
                        result_load              = 1'b1;
                        result_next.result_value = sat_q(49'(emit_sum));
                        result_next.result_row   = op_reg.raw_row;
                        result_next.last_row     = op_reg.last;
                        result_next.status       = STATUS_EMITTED;
                        state_next               = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            clear_busy_reg   <= 1'b1;
            clear_addr_reg   <= '0;
            column_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            column_reg <= column_next;
            if (clear_busy_reg)
            begin
                if (clear_addr_reg == AW'(MAX_ROWS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
                else
                begin
                    clear_addr_reg <= clear_addr_reg + 1'b1;
                end
            end
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg   <= op;
            addr_reg <= op_addr;
        end
        if (state_reg == ST_IDLE)
        begin
            product_reg <= 64'(column_reg) * 64'(op.value);
        end
        if (state_reg == ST_RND)
        begin
            qprod_reg <= rounded[63:16];
        end
        if (result_load)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for csc_sparse_matrix_vector_multiply. A directed table
// covers reset contents, Q16.16 extremes with saturation, dropped rows, every
// output mode, the unused command and clamped row counts. Randomized column
// streams follow under several row counts and idle/stall profiles. Every
// result transfer is compared field by field to a table entry or in-bench predictor.
// ============================================================================
module testbench;
    import cscspmv_pkg::*;

    localparam int ROWS          = MAX_ROWS_DEFAULT;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [63:0] Q_HI = 64'sd2147483647;
    localparam logic signed [63:0] Q_LO = -64'sd2147483648;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        item_t                  it;
        bit                     typed;
        result_t                want;
    } step_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic signed [31:0]    row_acc [ROWS];
    logic signed [31:0]    column_x;
    int unsigned           emit_row;
    logic [NUM_ROWS_W-1:0] rows_setting;
    logic [MODE_W-1:0]     mode_setting;
    result_t               row_results_due [$];

    int fail_count = 0;
    int items_sent = 0;
    int emits_seen = 0;
    int drops_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_orders = 0;
    int hold_orders_seen = 0;
    int hold_left = 0;
    int cycle_count;

    step_t directed_steps [$];

    csc_sparse_matrix_vector_multiply #(
        .MAX_ROWS (ROWS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .item             (item),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic signed [31:0] saturate(input logic signed [63:0] v);
        if (v > Q_HI)
            return Q_HI[31:0];
        if (v < Q_LO)
            return Q_LO[31:0];
        return v[31:0];
    endfunction

    function automatic int unsigned active_rows();
        if (rows_setting == 0)
            return 1;
        if (rows_setting > ROWS)
            return ROWS;
        return rows_setting;
    endfunction

    // Advances the predictor by one accepted item; returns 1 with the row output
    // when the item produces one.
    function automatic bit spmv_advance(input item_t it, output result_t r);
        int unsigned        n;
        int unsigned        row;
        logic signed [63:0] x64;
        logic signed [63:0] v64;
        logic signed [63:0] a64;
        logic signed [63:0] prod;
        n = active_rows();
        r = '0;
        v64 = $signed(it.value);
        case (it.command)
            CMD_BEGIN:
            begin
                column_x = $signed(it.value);
                return 1'b0;
            end
            CMD_NONZERO:
            begin
                if (it.row_index >= n)
                begin
                    r.result_row = it.row_index;
                    r.status = STATUS_DROPPED;
                    return 1'b1;
                end
                x64 = column_x;
                // round half up, floor shift
                prod = (x64 * v64 + 64'sd32768) >>> 16;
                a64 = row_acc[it.row_index];
                row_acc[it.row_index] = saturate(a64 + prod);
                return 1'b0;
            end
            CMD_EMIT:
            begin
                row = (emit_row >= n) ? 0 : emit_row;
                a64 = row_acc[row];
                case (mode_setting)
                    MODE_STORE:  r.result_value = a64[31:0];
                    MODE_NEGATE: r.result_value = saturate(-a64);
                    MODE_ADD:    r.result_value = saturate(v64 + a64);
                    default:     r.result_value = saturate(v64 - a64);
                endcase
                row_acc[row] = '0;
                r.result_row = row[ROW_W-1:0];
                r.last_row = (row == n - 1);
                r.status = STATUS_EMITTED;
                emit_row = r.last_row ? 0 : row + 1;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic item_t make_item(input logic [CMD_W-1:0] cmd,
                                        input logic [ROW_W-1:0] row,
                                        input logic [VALUE_W-1:0] val);
        item_t it;
        it.command = cmd;
        it.row_index = row;
        it.value = val;
        return it;
    endfunction

    function automatic result_t row_out(input logic [VALUE_W-1:0] val,
                                        input logic [ROW_W-1:0] row,
                                        input logic last, input logic status);
        result_t r;
        r.result_value = val;
        r.result_row = row;
        r.last_row = last;
        r.status = status;
        return r;
    endfunction

    function automatic step_t entry_item(input logic [CMD_W-1:0] cmd,
                                         input logic [ROW_W-1:0] row,
                                         input logic [VALUE_W-1:0] val);
        step_t s;
        s.is_write = 1'b0;
        s.reg_index = '0;
        s.reg_value = '0;
        s.it = make_item(cmd, row, val);
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_t entry_check(input logic [CMD_W-1:0] cmd,
                                          input logic [ROW_W-1:0] row,
                                          input logic [VALUE_W-1:0] val,
                                          input result_t want);
        step_t s;
        s = entry_item(cmd, row, val);
        s.typed = 1'b1;
        s.want = want;
        return s;
    endfunction

    function automatic step_t entry_reg(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s = entry_item(CMD_UNUSED, '0, '0);
        s.is_write = 1'b1;
        s.reg_index = idx;
        s.reg_value = data;
        return s;
    endfunction

    function automatic logic signed [31:0] rand_q16();
        int unsigned        pick;
        logic signed [31:0] s;
        pick = $urandom_range(9, 0);
        if (pick < 4)
            return $urandom;
        if (pick < 8)
        begin
            s = $urandom_range(32'h0004_0000, 0);
            return s - 32'sh0002_0000;
        end
        case ($urandom_range(5, 0))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0001_0000;
            3:       return 32'hFFFF_0000;
            4:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic push_item(input item_t it, input bit typed = 1'b0,
                             input result_t want = '0);
        result_t predicted;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (it.command != CMD_UNUSED)
            items_sent++;
        if (spmv_advance(it, predicted))
            row_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (row_results_due.size() != 0);
    endtask

    // Dropped-free items leave no result, so give the back end time to retire.
    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
        if (idx == REG_NUM_ROWS)
            rows_setting = data[NUM_ROWS_W-1:0];
        else
            mode_setting = data[MODE_W-1:0];
    endtask

    task automatic run_phase(input int rows, input int mode, input int send_pct,
                             input int recv_pct, input int budget,
                             input bit pause_per_product, input bit long_hold);
        int unsigned      n;
        int               stop_at;
        logic [ROW_W-1:0] row;
        quiesce();
        write_reg(REG_NUM_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_OUTPUT_MODE, CFG_DATA_W'(mode));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold)
            hold_orders++;
        stop_at = items_sent + budget;
        n = active_rows();
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99, 0) < 80)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    push_item(make_item(CMD_BEGIN, ROW_W'($urandom), rand_q16()));
                    repeat ($urandom_range(5, 0))
                    begin
                        row = ($urandom_range(19, 0) == 0) ? ROW_W'($urandom)
                                                           : ROW_W'($urandom_range(n - 1, 0));
                        push_item(make_item(CMD_NONZERO, row, rand_q16()));
                    end
                end
                repeat ((n <= 32) ? n : $urandom_range(16, 1))
                    push_item(make_item(CMD_EMIT, ROW_W'($urandom), rand_q16()));
                if (pause_per_product)
                    drain_results();
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    push_item(make_item(CMD_W'($urandom), ROW_W'($urandom), $urandom));
            end
        end
    endtask

    task automatic check_row_output(input result_t got);
        result_t want;
        if (row_results_due.size() == 0)
        begin
            $display("%0t: unexpected transfer value %0d row %0d last %0b status %0b",
                     $time, got.result_value, got.result_row, got.last_row, got.status);
            fail_count++;
        end
        else
        begin
            want = row_results_due.pop_front();
            if (got.status == STATUS_DROPPED)
                drops_seen++;
            else
                emits_seen++;
            if (got.result_value !== want.result_value)
            begin
                $display("%0t: result_value expected %0d got %0d",
                         $time, want.result_value, got.result_value);
                fail_count++;
            end
            if (got.result_row !== want.result_row)
            begin
                $display("%0t: result_row expected %0d got %0d",
                         $time, want.result_row, got.result_row);
                fail_count++;
            end
            if (got.last_row !== want.last_row)
            begin
                $display("%0t: last_row expected %0b got %0b",
                         $time, want.last_row, got.last_row);
                fail_count++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0b got %0b",
                         $time, want.status, got.status);
                fail_count++;
            end
        end
    endtask

    // result side: check transfers, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_row_output(result);
        if (hold_orders != hold_orders_seen)
        begin
            hold_orders_seen <= hold_orders;
            hold_left <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < ROWS; i++)
            row_acc[i] = '0;
        column_x = '0;
        emit_row = 0;
        rows_setting = NUM_ROWS_RESET;
        mode_setting = OUTPUT_MODE_RESET;

        directed_steps = '{
            entry_check(CMD_EMIT, 12'd0, 32'h0, row_out(32'h0, 12'd0, 1'b0, STATUS_EMITTED)),
            entry_item(CMD_NONZERO, 12'd4095, 32'h7FFF_FFFF),
            entry_reg(REG_NUM_ROWS, 13'd4),
            entry_check(CMD_NONZERO, 12'd4, 32'h1, row_out(32'h0, 12'd4, 1'b0, STATUS_DROPPED)),
            entry_check(CMD_NONZERO, 12'd4095, 32'h8000_0000,
                        row_out(32'h0, 12'd4095, 1'b0, STATUS_DROPPED)),
            entry_item(CMD_BEGIN, 12'hFFF, 32'h7FFF_FFFF),
            entry_item(CMD_NONZERO, 12'd0, 32'h7FFF_FFFF),
            entry_item(CMD_NONZERO, 12'd0, 32'h7FFF_FFFF),
            entry_item(CMD_BEGIN, 12'd0, 32'h8000_0000),
            entry_item(CMD_NONZERO, 12'd1, 32'h8000_0000),
            entry_item(CMD_NONZERO, 12'd2, 32'h7FFF_FFFF),
            entry_item(CMD_BEGIN, 12'd0, 32'h0001_0000),
            entry_item(CMD_NONZERO, 12'd3, 32'hFFFF_8000),
            entry_item(CMD_NONZERO, 12'd3, 32'h0000_0001),
            entry_reg(REG_OUTPUT_MODE, CFG_DATA_W'(MODE_NEGATE)),
            entry_item(CMD_EMIT, 12'd0, 32'h0),
            entry_item(CMD_EMIT, 12'd0, 32'h0),
            entry_item(CMD_EMIT, 12'd0, 32'h0),
            entry_item(CMD_EMIT, 12'd0, 32'h0),
            entry_reg(REG_NUM_ROWS, 13'd0),
            entry_check(CMD_NONZERO, 12'd1, 32'h5, row_out(32'h0, 12'd1, 1'b0, STATUS_DROPPED)),
            entry_check(CMD_EMIT, 12'd0, 32'h0, row_out(32'h0, 12'd0, 1'b1, STATUS_EMITTED)),
            entry_reg(REG_NUM_ROWS, 13'd8191),
            entry_reg(REG_OUTPUT_MODE, CFG_DATA_W'(MODE_ADD)),
            entry_item(CMD_UNUSED, 12'hABC, 32'h5A5A_5A5A),
            entry_check(CMD_EMIT, 12'd0, 32'h7FFF_FFFF,
                        row_out(32'h7FFF_FFFF, 12'd0, 1'b0, STATUS_EMITTED)),
            entry_item(CMD_EMIT, 12'd0, 32'h8000_0000),
            entry_item(CMD_BEGIN, 12'd0, 32'h0001_0000),
            entry_item(CMD_NONZERO, 12'd0, 32'h0001_0000),
            entry_reg(REG_OUTPUT_MODE, CFG_DATA_W'(MODE_SUBTRACT)),
            entry_reg(REG_NUM_ROWS, 13'd2),
            entry_item(CMD_EMIT, 12'd0, 32'h8000_0000)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_write)
            begin
                quiesce();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end
            else
            begin
                push_item(directed_steps[i].it, directed_steps[i].typed,
                          directed_steps[i].want);
            end
        end

        run_phase(4,    MODE_STORE,    0,  0,  120, 1'b0, 1'b0);
        run_phase(1,    MODE_NEGATE,   67, 0,  120, 1'b0, 1'b0);
        run_phase(16,   MODE_ADD,      0,  67, 150, 1'b0, 1'b0);
        run_phase(7,    MODE_SUBTRACT, 23, 23, 150, 1'b0, 1'b1);
        run_phase(4096, MODE_STORE,    0,  0,  120, 1'b0, 1'b0);
        run_phase(0,    MODE_ADD,      23, 23, 80,  1'b0, 1'b0);
        run_phase(8191, MODE_SUBTRACT, 0,  67, 80,  1'b0, 1'b0);
        run_phase(3,    MODE_NEGATE,   67, 0,  120, 1'b1, 1'b0);
        run_phase(12,   MODE_STORE,    23, 23, 150, 1'b0, 1'b0);
        run_phase($urandom_range(32, 1), $urandom_range(3, 0), 0, 0, 200, 1'b0, 1'b0);
        quiesce();

        $display("tb: %0d items sent, %0d rows emitted, %0d nonzeros dropped, %0d mismatches",
                 items_sent, emits_seen, drops_seen, fail_count);
        $display("tb: row counts 0..8191 incl. clamping, all output modes, long result hold");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
